// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that post holds in the same cycle as pre, outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that post holds in the cycle after pre, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/bmpalloc_pkg.sv
// Package with shared types and constants of the bitmap identifier allocator.
package bmpalloc_pkg;

    localparam int MODE_W     = 1;
    localparam int FREE_ID_W  = 11;
    localparam int ALLOC_ID_W = 10;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the accepted transaction and pick a word
        logic clear_wr;  // write one zero word of the clearing pass
        logic rd;        // read the selected word
        logic commit;    // write back the word and load the result
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last; // clearing pass is at its last word
        logic drop;       // incoming free request is out of range
        logic is_alloc;   // latched transaction is an allocate request
        logic out_stall;  // result register is full and not taken
    } dp_status_t;

endpackage

// File: rtl/bmpalloc_ctrl.sv
// Controller state machine of the bitmap identifier allocator.
module bmpalloc_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bmpalloc_pkg::dp_status_t status,
    output bmpalloc_pkg::dp_cmd_t    cmd
);

    bmpalloc_pkg::ctrl_state_t state_reg;
    bmpalloc_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmpalloc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmpalloc_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = bmpalloc_pkg::ST_IDLE;
                end
            end
            bmpalloc_pkg::ST_IDLE:
            begin
                // drop out-of-range frees right at acceptance
                if (in_valid && !status.drop)
                begin
                    state_next = bmpalloc_pkg::ST_READ;
                end
            end
            bmpalloc_pkg::ST_READ:
            begin
                state_next = bmpalloc_pkg::ST_WRITE;
            end
            bmpalloc_pkg::ST_WRITE:
            begin
                if (!(status.is_alloc && status.out_stall))
                begin
                    state_next = bmpalloc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmpalloc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            bmpalloc_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            bmpalloc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bmpalloc_pkg::ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            bmpalloc_pkg::ST_WRITE:
            begin
                // hold an allocate result until the output register frees up
                cmd.commit = !(status.is_alloc && status.out_stall);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/bmpalloc_dp.sv
// Datapath of the bitmap identifier allocator: bitmap memory, summary and result register.
module bmpalloc_dp
#(
    parameter int ID_COUNT  = 1024,
    parameter int WORD_BITS = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bmpalloc_pkg::dp_cmd_t                  cmd,
    output bmpalloc_pkg::dp_status_t               status,
    input  logic [bmpalloc_pkg::MODE_W-1:0]        mode,
    input  logic [bmpalloc_pkg::FREE_ID_W-1:0]     free_id,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic                                   alloc_ok,
    output logic [bmpalloc_pkg::ALLOC_ID_W-1:0]    alloc_id
);

    localparam int NUM_WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int IDW       = $clog2(NUM_WORDS * WORD_BITS) + 1;
    // word index of a freed id: multiply by a rounded-up reciprocal
    localparam int DIV_K     = bmpalloc_pkg::FREE_ID_W + BW;
    localparam int RECIP_W   = DIV_K + 1;
    localparam int PROD_W    = bmpalloc_pkg::FREE_ID_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_K) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic [bmpalloc_pkg::MODE_W-1:0]    mode_reg;
    logic [bmpalloc_pkg::FREE_ID_W-1:0] fid_reg;
    logic [WW-1:0]                      word_reg;
    logic                               any_free_reg;
    logic [IDW-1:0]                     base_reg;
    logic [BW-1:0]                      fbit_reg;
    logic [WORD_BITS-1:0]               rdata_reg;
    logic [WW-1:0]                      clr_cnt_reg;
    logic [NUM_WORDS-1:0]               full_reg;
    logic                               out_valid_reg;
    logic                               alloc_ok_reg;
    logic [bmpalloc_pkg::ALLOC_ID_W-1:0] alloc_id_reg;

    logic [WW-1:0]        pick_word;
    logic                 pick_any;
    logic                 in_range;
    logic [PROD_W-1:0]    fid_prod;
    logic [WW-1:0]        fid_word;
    logic [IDW-1:0]       base_next;
    logic [BW-1:0]        fbit_next;
    logic [WORD_BITS-1:0] vmask;
    logic [WORD_BITS-1:0] freebits;
    logic [BW-1:0]        abit;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    logic [WORD_BITS-1:0] new_word;
    logic                 is_free;
    logic                 wr_en;
    logic                 full_set;
    logic [IDW-1:0]       id_sum;

    // lowest word that still has a free identifier
    always_comb
    begin
        pick_word = '0;
        pick_any  = 1'b0;
        for (int w = NUM_WORDS - 1; w >= 0; w--)
        begin
            if (!full_reg[w])
            begin
                pick_word = WW'(w);
                pick_any  = 1'b1;
            end
        end
    end

    assign in_range = 32'(free_id) < 32'(ID_COUNT);
    assign fid_prod = PROD_W'(free_id) * PROD_W'(RECIP);
    assign fid_word = WW'(fid_prod >> DIV_K);

    assign base_next = IDW'(word_reg) * IDW'(WORD_BITS);
    assign fbit_next = BW'(32'(fid_reg) - 32'(base_next));

    // identifiers at or above ID_COUNT in the last word count as used
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            vmask[i] = (32'(base_reg) + 32'(i)) < 32'(ID_COUNT);
        end
    end

    assign freebits = ~rdata_reg & vmask;

    always_comb
    begin
        abit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (freebits[i])
            begin
                abit = BW'(i);
            end
        end
    end

    assign set_word = rdata_reg | (WORD_BITS'(1) << abit);
    assign clr_word = rdata_reg & ~(WORD_BITS'(1) << fbit_reg);
    assign is_free  = (mode_reg == bmpalloc_pkg::MODE_FREE);
    assign new_word = is_free ? clr_word : set_word;
    assign wr_en    = cmd.commit && (is_free || any_free_reg);
    assign full_set = &(set_word | ~vmask);
    assign id_sum   = base_reg + IDW'(abit);

    assign status.clear_last = (clr_cnt_reg == WW'(NUM_WORDS - 1));
    assign status.drop       = (mode == bmpalloc_pkg::MODE_FREE) && !in_range;
    assign status.is_alloc   = (mode_reg == bmpalloc_pkg::MODE_ALLOC);
    assign status.out_stall  = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[word_reg] <= new_word;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[word_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= mode;
            fid_reg      <= free_id;
            word_reg     <= (mode == bmpalloc_pkg::MODE_FREE) ? fid_word : pick_word;
            any_free_reg <= pick_any;
        end
        if (cmd.rd)
        begin
            base_reg <= base_next;
            fbit_reg <= fbit_next;
        end
        if (cmd.commit && status.is_alloc)
        begin
            alloc_ok_reg <= any_free_reg;
            alloc_id_reg <= any_free_reg ? bmpalloc_pkg::ALLOC_ID_W'(id_sum) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr && !status.clear_last)
            begin
                clr_cnt_reg <= clr_cnt_reg + WW'(1);
            end
            if (wr_en)
            begin
                full_reg[word_reg] <= is_free ? 1'b0 : full_set;
            end
            if (cmd.commit && status.is_alloc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign alloc_ok  = alloc_ok_reg;
    assign alloc_id  = alloc_id_reg;

endmodule

// File: rtl/bitmap_id_allocator_top.sv
// Top level of the bitmap identifier allocator.
//
// Input channel (in_valid/in_ready) carries one request per transaction:
// mode 0 allocates the lowest free identifier, mode 1 frees free_id.
// Output channel (out_valid/out_ready) carries one result per allocate
// request: alloc_ok and alloc_id; alloc_id is zero when every id is in use.
// Free requests produce no output transaction; a free of an id at or above
// ID_COUNT is accepted and dropped.
// Sequence: a request picks a word from the per-word full summary when it
// is accepted, then does one read of the bitmap memory and one write-back;
// out_valid is set by the write-back. in_ready is high only between
// requests, so a new request is accepted only after the last one is done.
// Reset: the bitmap memory is cleared by a pass of one word per cycle over
// all ceil(ID_COUNT / WORD_BITS) words; in_ready stays low during it.
// Receiver stall: the result register holds its transaction; a following
// free request still completes, a following allocate waits in write-back
// until the register is taken.
module bitmap_id_allocator_top
#(
    parameter int ID_COUNT  = 1024,
    parameter int WORD_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bmpalloc_pkg::MODE_W-1:0]     mode,
    input  logic [bmpalloc_pkg::FREE_ID_W-1:0]  free_id,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                alloc_ok,
    output logic [bmpalloc_pkg::ALLOC_ID_W-1:0] alloc_id
);

    bmpalloc_pkg::dp_cmd_t    cmd;
    bmpalloc_pkg::dp_status_t status;

    // sequence clear, accept, read and write-back
    bmpalloc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold the bitmap, the full summary and the result register
    bmpalloc_dp
    #(
        .ID_COUNT  (ID_COUNT),
        .WORD_BITS (WORD_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .mode      (mode),
        .free_id   (free_id),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .alloc_ok  (alloc_ok),
        .alloc_id  (alloc_id)
    );

endmodule

// File: rtl/bmpalloc_checker.sv
// Port-level checker of the bitmap identifier allocator and its bind.
`include "assert_macros.svh"

module bmpalloc_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [bmpalloc_pkg::MODE_W-1:0]     mode,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                alloc_ok,
    input logic [bmpalloc_pkg::ALLOC_ID_W-1:0] alloc_id
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(alloc_ok) && $stable(alloc_id), "stalled result changed")

    `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && !alloc_ok, alloc_id == '0, "failed allocation carries a nonzero id")

    `ASSERT_NEXT(a_alloc_busy, clk, rst_n, in_valid && in_ready && (mode == bmpalloc_pkg::MODE_ALLOC), !in_ready, "ready right after an allocate transaction")

    `ASSERT_IMPL(a_result_timing, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && (mode == bmpalloc_pkg::MODE_ALLOC), 3), "result without an allocate three edges earlier")

endmodule

bind bitmap_id_allocator_top bmpalloc_checker u_bmpalloc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .alloc_ok  (alloc_ok),
    .alloc_id  (alloc_id)
);
